// File: hdl/sor_pkg.sv
// Shared types and constants for the SOR grid solver.
`default_nettype none
package sor_pkg;
  localparam int unsigned MaxRowsDef = 16;
  localparam int unsigned MaxColsDef = 32;
  localparam int unsigned DataW = 32;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [1:0] ActLoad  = 2'd0;
  localparam logic [1:0] ActSolve = 2'd1;
  localparam logic [1:0] ActRead  = 2'd2;

  localparam logic [2:0] RegRows   = 3'd0;
  localparam logic [2:0] RegCols   = 3'd1;
  localparam logic [2:0] RegCoefX  = 3'd2;
  localparam logic [2:0] RegCoefY  = 3'd3;
  localparam logic [2:0] RegInv    = 3'd4;
  localparam logic [2:0] RegRelax  = 3'd5;
  localparam logic [2:0] RegTol    = 3'd6;
  localparam logic [2:0] RegSweeps = 3'd7;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage
`default_nettype wire

// File: hdl/sor_poisson_grid_solver_core.sv
// Top level of the SOR Poisson grid solver: control, arithmetic and stores.
//
// channel | signals                                                  | dir
// in      | in_valid_i in_stall_o action_i row_i col_i point_value_i  | in
//         | source_value_i                                           |
// out     | out_valid_o out_stall_i read_value_o sweeps_done_o       | out
//         | converged_o                                              |
// cfg     | cfg_we_i cfg_idx_i cfg_wdata_i                           | in
//
// After reset a clearing pass writes zero to every store entry, with the input
// stalled. Load and read pass through StRdWait and StOut before the word is
// registered for output. A solve visits each interior point through one shared
// 34x33 multiplier (stencil reads in StPtE to StPtU, then 10 arithmetic steps).
// The output register holds a word under stall; a new item is taken at the edge
// where the pending word leaves.
`default_nettype none
module sor_poisson_grid_solver_core #(
  parameter int unsigned MAX_ROWS = sor_pkg::MaxRowsDef,
  parameter int unsigned MAX_COLS = sor_pkg::MaxColsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [1:0]          action_i,
  input  wire logic [3:0]          row_i,
  input  wire logic [4:0]          col_i,
  input  wire logic signed [31:0]  point_value_i,
  input  wire logic signed [31:0]  source_value_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic signed [31:0]       read_value_o,
  output logic [15:0]              sweeps_done_o,
  output logic                     converged_o,
  input  wire logic                cfg_we_i,
  input  wire logic [sor_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [sor_pkg::DataW-1:0]   cfg_wdata_i
);
  localparam int unsigned Depth = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned RW = $clog2(MAX_ROWS);
  localparam int unsigned CW = $clog2(MAX_COLS);

  // configuration
  logic [4:0]  rows_q;
  logic [5:0]  cols_q;
  logic [31:0] coefx_q, coefy_q, inv_q, relax_q;
  logic [30:0] tol_q;
  logic [15:0] maxsw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= 5'd11;
      cols_q  <= 6'd21;
      coefx_q <= 32'd26214400;
      coefy_q <= 32'd6553600;
      inv_q   <= 32'd4294967;
      relax_q <= 32'd1073741824;
      tol_q   <= 31'd168;
      maxsw_q <= 16'd65535;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sor_pkg::RegRows:   rows_q  <= cfg_wdata_i[4:0];
        sor_pkg::RegCols:   cols_q  <= cfg_wdata_i[5:0];
        sor_pkg::RegCoefX:  coefx_q <= cfg_wdata_i;
        sor_pkg::RegCoefY:  coefy_q <= cfg_wdata_i;
        sor_pkg::RegInv:    inv_q   <= cfg_wdata_i;
        sor_pkg::RegRelax:  relax_q <= cfg_wdata_i;
        sor_pkg::RegTol:    tol_q   <= cfg_wdata_i[30:0];
        sor_pkg::RegSweeps: maxsw_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // clamped sizes as last index (nr-1, nc-1), in 9 bits to cover any parameter
  logic [8:0] nr_m1, nc_m1;
  logic [31:0] w_eff;
  logic [15:0] limit;
  always_comb begin
    nr_m1 = {4'd0, rows_q} - 9'd1;
    if (rows_q < 5'd3) nr_m1 = 9'd2;
    if ({4'd0, rows_q} > 9'(MAX_ROWS)) nr_m1 = 9'(MAX_ROWS - 1);
    nc_m1 = {3'd0, cols_q} - 9'd1;
    if (cols_q < 6'd3) nc_m1 = 9'd2;
    if ({3'd0, cols_q} > 9'(MAX_COLS)) nc_m1 = 9'(MAX_COLS - 1);
    w_eff = (relax_q > 32'h8000_0000) ? 32'h8000_0000 : relax_q;
    limit = (maxsw_q == 16'd0) ? 16'd1 : maxsw_q;
  end

  // memories
  logic          g_we, s_we;
  logic [AW-1:0] g_wa, s_wa, g_ra, s_ra;
  logic [31:0]   g_wd, s_wd, g_rd, s_rd;

  sor_ram #(.Width(32), .Depth(Depth)) u_grid (
    .clk_i, .we_i(g_we), .waddr_i(g_wa), .wdata_i(g_wd), .raddr_i(g_ra), .rdata_o(g_rd));
  sor_ram #(.Width(32), .Depth(Depth)) u_src (
    .clk_i, .we_i(s_we), .waddr_i(s_wa), .wdata_i(s_wd), .raddr_i(s_ra), .rdata_o(s_rd));

  typedef enum logic [4:0] {
    StClear, StIdle, StRdWait, StOut,
    StPtE, StPtW, StPtN, StPtS, StPtU,
    StMulX, StMulY, StSum, StInvLo, StInvHi, StGs,
    StRelA, StRelB, StRelC, StWrite, StSweepEnd
  } state_e;

  state_e        st_q;
  logic [AW:0]   clr_q;
  logic [RW-1:0] r_q;
  logic [CW-1:0] c_q;
  logic [AW-1:0] rd_addr;
  logic          inside_q, isread_q;
  logic signed [31:0] e_q, wv_q, n_q, sv_q, u_q, gs_q, nv_q;
  logic signed [33:0] sum_q;
  logic signed [50:0] acc_q;
  logic [49:0]        mag_q;
  logic               neg_q;
  logic [63:0]        plo_q;
  logic signed [63:0] tx_q, rel_q;
  logic [15:0] sweeps_q;
  logic [31:0] big_q;
  logic        conv_q;
  logic        ov_q;
  logic signed [31:0] rv_q;

  // shared multiplier: 34-bit signed operand x 33-bit signed operand
  logic signed [33:0] ma;
  logic        [32:0] mb;
  logic signed [67:0] mp;
  assign mp = ma * $signed(mb);

  // row-major address, row stride MAX_COLS
  logic [AW-1:0] k;
  assign k = AW'(32'(r_q) * MAX_COLS + 32'(c_q));

  always_comb begin
    ma = '0;
    mb = '0;
    case (st_q)
      StMulX:  begin ma = sum_q; mb = {1'b0, coefx_q}; end
      StMulY:  begin ma = 34'($signed(n_q)) + 34'($signed(sv_q)); mb = {1'b0, coefy_q}; end
      StInvLo: begin ma = $signed({2'b0, mag_q[31:0]}); mb = {1'b0, inv_q}; end
      StInvHi: begin ma = $signed({16'b0, mag_q[49:32]}); mb = {1'b0, inv_q}; end
      StRelA:  begin ma = 34'($signed(u_q)); mb = 33'(33'sh4000_0000 - $signed({1'b0, w_eff})); end
      StRelB:  begin ma = 34'($signed(gs_q)); mb = {1'b0, w_eff}; end
      default: ;
    endcase
  end

  // floor by 2^16 of signed product is plain arithmetic shift
  logic signed [63:0] q64;
  logic signed [63:0] diff;
  logic [31:0] ch;
  always_comb begin
    q64  = rel_q + 64'(mp) ;
    diff = 64'($signed(nv_q)) - 64'($signed(u_q));
    if (diff < 0) diff = -diff;
    ch = (diff > 64'sh0_ffff_ffff) ? 32'hffff_ffff : diff[31:0];
  end

  always_comb begin
    g_we = 1'b0; g_wa = k; g_wd = nv_q;
    s_we = 1'b0; s_wa = k; s_wd = '0;
    rd_addr = k;
    case (st_q)
      StClear: begin
        g_we = 1'b1; s_we = 1'b1; g_wa = clr_q[AW-1:0]; s_wa = clr_q[AW-1:0];
        g_wd = '0;
      end
      StIdle: begin
        rd_addr = AW'({28'd0, row_i} * MAX_COLS + {27'd0, col_i});
        if (in_valid_i && !in_stall_o && action_i == sor_pkg::ActLoad &&
            {28'd0, row_i} < 32'(MAX_ROWS) && {27'd0, col_i} < 32'(MAX_COLS)) begin
          g_we = 1'b1; s_we = 1'b1; g_wa = rd_addr; s_wa = rd_addr;
          g_wd = point_value_i; s_wd = source_value_i;
        end
      end
      StPtE: rd_addr = k + AW'(1);
      StPtW: rd_addr = k - AW'(1);
      StPtN: rd_addr = k - AW'(MAX_COLS);
      StPtS: rd_addr = k + AW'(MAX_COLS);
      StWrite: g_we = 1'b1;
      default: ;
    endcase
  end
  assign g_ra = rd_addr;
  assign s_ra = k;

  // a pending word leaving this edge frees the input
  assign in_stall_o = (st_q != StIdle) || (ov_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClear;
      clr_q <= '0;
      r_q <= '0; c_q <= '0;
      sweeps_q <= '0; big_q <= '0; conv_q <= 1'b0;
      ov_q <= 1'b0;
      rv_q <= '0;
      inside_q <= 1'b0; isread_q <= 1'b0;
    end else begin
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      case (st_q)
        StClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (AW+1)'(Depth - 1)) st_q <= StIdle;
        end
        StIdle: if (in_valid_i && !in_stall_o) begin
          inside_q <= {28'd0, row_i} < 32'(MAX_ROWS) && {27'd0, col_i} < 32'(MAX_COLS);
          isread_q <= action_i == sor_pkg::ActRead;
          rv_q <= (action_i == sor_pkg::ActLoad &&
                   {28'd0, row_i} < 32'(MAX_ROWS) && {27'd0, col_i} < 32'(MAX_COLS))
                  ? point_value_i : 32'sd0;
          if (action_i == sor_pkg::ActSolve) begin
            sweeps_q <= '0; conv_q <= 1'b0; big_q <= '0;
            r_q <= RW'(1); c_q <= CW'(1);
            st_q <= StPtE;
          end else st_q <= StRdWait;
        end
        StRdWait: begin
          if (isread_q && inside_q) rv_q <= g_rd;
          st_q <= StOut;
        end
        StOut: begin
          ov_q <= 1'b1;
          st_q <= StIdle;
        end
        StPtE: st_q <= StPtW;
        StPtW: begin e_q <= g_rd; st_q <= StPtN; end
        StPtN: begin wv_q <= g_rd; st_q <= StPtS; end
        StPtS: begin
          sum_q <= 34'(e_q) + 34'(wv_q);
          n_q <= g_rd;
          st_q <= StPtU;
        end
        StPtU: begin sv_q <= g_rd; st_q <= StMulX; end
        StMulX: begin
          sum_q <= 34'(e_q) + 34'(wv_q);
          st_q <= StMulY;
        end
        StMulY: begin
          u_q <= g_rd;
          tx_q <= 64'(mp >>> 16);
          st_q <= StSum;
        end
        default: ;
      endcase
      // arithmetic steps beyond the stencil reads
      case (st_q)
        StMulX: tx_q <= 64'(mp >>> 16);
        StMulY: begin
          acc_q <= 51'(tx_q) + 51'(mp >>> 16) + 51'($signed(s_rd));
        end
        StSum: begin
          neg_q <= acc_q < 0;
          mag_q <= (acc_q < 0) ? 50'(-acc_q) : 50'(acc_q);
          st_q  <= StInvLo;
        end
        StInvLo: begin plo_q <= 64'(mp); st_q <= StInvHi; end
        StInvHi: begin
          tx_q <= 64'(mp) + 64'(plo_q[63:32]) + 64'(neg_q && plo_q[31:0] != 0);
          st_q <= StGs;
        end
        StGs: begin
          gs_q <= sor_pkg::sat32(neg_q ? -tx_q : tx_q);
          st_q <= StRelA;
        end
        StRelA: begin rel_q <= 64'(mp); st_q <= StRelB; end
        StRelB: begin rel_q <= q64 >>> 30; st_q <= StRelC; end
        StRelC: begin nv_q <= sor_pkg::sat32(rel_q); st_q <= StWrite; end
        StWrite: begin
          if (ch > big_q) big_q <= ch;
          if (9'(c_q) + 9'd1 < nc_m1) begin
            c_q <= c_q + 1'b1; st_q <= StPtE;
          end else if (9'(r_q) + 9'd1 < nr_m1) begin
            c_q <= CW'(1); r_q <= r_q + 1'b1; st_q <= StPtE;
          end else st_q <= StSweepEnd;
        end
        StSweepEnd: begin
          sweeps_q <= sweeps_q + 1'b1;
          r_q <= RW'(1); c_q <= CW'(1);
          if ({1'b0, big_q} <= {1'b0, tol_q}) begin
            conv_q <= 1'b1; rv_q <= '0; ov_q <= 1'b1; st_q <= StIdle;
          end else if (sweeps_q + 1'b1 >= limit) begin
            rv_q <= '0; ov_q <= 1'b1; st_q <= StIdle;
          end else begin
            big_q <= '0; st_q <= StPtE;
          end
        end
        default: ;
      endcase
    end
  end

  // u read: the centre value arrives in StMulY from the read issued in StMulX
  // (rd_addr defaults to k there)

  assign out_valid_o   = ov_q;
  assign read_value_o  = rv_q;
  assign sweeps_done_o = sweeps_q;
  assign converged_o   = conv_q;

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIdle) |-> in_stall_o) else $error("input taken while busy");
  a_no_write_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> !(g_we && st_q == StWrite)) else $error("grid written while word pending");
  a_sweep_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StSweepEnd) |-> (sweeps_q < limit)) else $error("sweep count beyond limit");
endmodule
`default_nettype wire

// File: hdl/sor_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module sor_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire
